// ===== sv/ook_tx_pkg.sv =====
// Package for the on-off keyed pulse-code transmitter.
// Item types, register indexes, reset values and widths shared by the RTL.
// No dependencies.
package ook_tx_pkg;

    localparam int MAX_BITS_DEF = 64;
    localparam int SYNC_UNITS   = 50;
    localparam int UNIT_CNT_W   = 6;
    localparam int TICK_W       = 16;
    localparam int REPEAT_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [TICK_W-1:0]   PULSE_UNIT_RST = TICK_W'(350);
    localparam logic [REPEAT_W-1:0] REPEAT_RST     = REPEAT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_UNIT = 2'd0,
        CFG_REPEAT     = 2'd1,
        CFG_TX_ENABLE  = 2'd2
    } cfg_reg_t;

    // req_type codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BITS = 3'b010,
        PH_GAP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic req_type;
        logic code_bit;
        logic last_bit;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic frame_done;
        logic load_rejected;
    } out_item_t;

endpackage

// ===== sv/pulse_code_ook_transmitter_unit.sv =====
// On-off keyed pulse-code transmitter, top level; depends on ook_tx_pkg.
// The result of each accepted item is registered in the output register.
// Throughput: one item per cycle; input stalls only while a result waits on a
// stalled output. The word sits in a rotating bit shift register, one bit per unit.
// Reset (rst_n low, async): idle, line low, word empty, registers at defaults.
module pulse_code_ook_transmitter_unit #(
    parameter int MaxBits = ook_tx_pkg::MAX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [ook_tx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ook_tx_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ook_tx_pkg::in_item_t                in_item,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output ook_tx_pkg::out_item_t               out_item
);

    // word length counts up to MaxBits inclusive
    localparam int LenW = $clog2(MaxBits + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ook_tx_pkg::TICK_W-1:0]   pulse_unit_reg;
    logic [ook_tx_pkg::REPEAT_W-1:0] repeat_reg;
    logic                            tx_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_unit_reg <= ook_tx_pkg::PULSE_UNIT_RST;
            repeat_reg     <= ook_tx_pkg::REPEAT_RST;
            tx_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ook_tx_pkg::CFG_PULSE_UNIT: pulse_unit_reg <= cfg_data;
                ook_tx_pkg::CFG_REPEAT:
                    repeat_reg <= cfg_data[ook_tx_pkg::REPEAT_W-1:0];
                ook_tx_pkg::CFG_TX_ENABLE:  tx_enable_reg <= cfg_data[0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    // code_reg holds the word; head (bit 0) is always the bit on the line
    // during the bits phase. Each bit advance rotates the first word_len
    // positions by one, so a full pass leaves the word back in place.
    logic [MaxBits-1:0]                code_reg, code_next, code_rot;
    logic [LenW-1:0]                   word_len_reg, word_len_next, len_m1;
    logic [LenW-1:0]                   bit_pos_reg, bit_pos_next, bit_pos_inc;
    logic [ook_tx_pkg::REPEAT_W-1:0]   reps_reg, reps_next, reps_inc;
    logic [ook_tx_pkg::TICK_W-1:0]     tick_reg, tick_next, tick_inc, unit_eff;
    logic [ook_tx_pkg::UNIT_CNT_W-1:0] ucnt_reg, ucnt_next, ucnt_inc;
    ook_tx_pkg::phase_t                phase_reg, phase_next;
    logic                              line_reg, line_next;
    logic                              done, rejected, busy;

    logic                              accept_in;
    logic                              out_valid_reg;
    ook_tx_pkg::out_item_t             out_item_reg;

    assign busy      = (phase_reg != ook_tx_pkg::PH_IDLE);
    assign in_stall  = out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;

    // a pulse unit of zero runs as one tick
    assign unit_eff    = (pulse_unit_reg == '0) ? ook_tx_pkg::TICK_W'(1) : pulse_unit_reg;
    assign len_m1      = word_len_reg - LenW'(1);
    assign bit_pos_inc = bit_pos_reg + LenW'(1);
    assign reps_inc    = reps_reg + ook_tx_pkg::REPEAT_W'(1);
    assign tick_inc    = tick_reg + ook_tx_pkg::TICK_W'(1);
    assign ucnt_inc    = ucnt_reg + ook_tx_pkg::UNIT_CNT_W'(1);

    // rotate the active part of the word by one place
    always_comb
    begin
        code_rot = code_reg >> 1;
        for (int i = 0; i < MaxBits; i++)
        begin
            if (LenW'(i) == len_m1)
                code_rot[i] = code_reg[0];
        end
    end

    always_comb
    begin
        code_next     = code_reg;
        word_len_next = word_len_reg;
        bit_pos_next  = bit_pos_reg;
        reps_next     = reps_reg;
        tick_next     = tick_reg;
        ucnt_next     = ucnt_reg;
        phase_next    = phase_reg;
        line_next     = line_reg;
        done          = 1'b0;
        rejected      = 1'b0;

        if (accept_in)
        begin
            if (in_item.req_type == ook_tx_pkg::REQ_LOAD)
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    if (word_len_reg >= LenW'(MaxBits))
                    begin
                        rejected = 1'b1;   // store full, bit dropped
                    end
                    else
                    begin
                        for (int i = 0; i < MaxBits; i++)
                        begin
                            if (LenW'(i) == word_len_reg)
                                code_next[i] = in_item.code_bit;
                        end
                        word_len_next = word_len_reg + LenW'(1);
                    end

                    if (in_item.last_bit)
                    begin
                        if (repeat_reg == '0 || !tx_enable_reg || word_len_next == '0)
                        begin
                            // sequence ends on the starting item
                            done          = 1'b1;
                            phase_next    = ook_tx_pkg::PH_IDLE;
                            line_next     = 1'b0;
                            word_len_next = '0;
                            bit_pos_next  = '0;
                            reps_next     = '0;
                            tick_next     = '0;
                            ucnt_next     = '0;
                        end
                        else
                        begin
                            phase_next   = ook_tx_pkg::PH_BITS;
                            bit_pos_next = '0;
                            reps_next    = '0;
                            tick_next    = '0;
                            ucnt_next    = '0;
                            // first bit may be the one written by this item
                            line_next    = (word_len_reg == '0) ? in_item.code_bit
                                                                : code_reg[0];
                        end
                    end
                end
            end
            else if (!busy)
            begin
                line_next = 1'b0;
            end
            else if (!tx_enable_reg)
            begin
                // disabled mid-sequence: finish at once
                done          = 1'b1;
                phase_next    = ook_tx_pkg::PH_IDLE;
                line_next     = 1'b0;
                word_len_next = '0;
                bit_pos_next  = '0;
                reps_next     = '0;
                tick_next     = '0;
                ucnt_next     = '0;
            end
            else if (tick_inc != '0 && tick_inc < unit_eff)
            begin
                tick_next = tick_inc;
            end
            else
            begin
                // unit boundary
                tick_next = '0;
                if (phase_reg == ook_tx_pkg::PH_BITS)
                begin
                    bit_pos_next = bit_pos_inc;
                    code_next    = code_rot;
                    if (bit_pos_inc >= word_len_reg || bit_pos_inc >= LenW'(MaxBits))
                    begin
                        phase_next = ook_tx_pkg::PH_GAP;
                        ucnt_next  = '0;
                        line_next  = 1'b0;
                    end
                    else
                    begin
                        line_next = code_rot[0];
                    end
                end
                else
                begin
                    ucnt_next = ucnt_inc;
                    line_next = 1'b0;
                    if (ucnt_inc >= ook_tx_pkg::UNIT_CNT_W'(ook_tx_pkg::SYNC_UNITS))
                    begin
                        reps_next = reps_inc;
                        if (reps_inc >= repeat_reg || reps_inc == '0)
                        begin
                            done          = 1'b1;
                            phase_next    = ook_tx_pkg::PH_IDLE;
                            word_len_next = '0;
                            bit_pos_next  = '0;
                            reps_next     = '0;
                            ucnt_next     = '0;
                        end
                        else
                        begin
                            // next pass over the word
                            phase_next   = ook_tx_pkg::PH_BITS;
                            bit_pos_next = '0;
                            ucnt_next    = '0;
                            line_next    = code_reg[0];
                        end
                    end
                end
            end
        end
    end

    // word bits: contents undefined until loaded, no reset
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= '0;
            bit_pos_reg  <= '0;
            reps_reg     <= '0;
            tick_reg     <= '0;
            ucnt_reg     <= '0;
            phase_reg    <= ook_tx_pkg::PH_IDLE;
            line_reg     <= 1'b0;
        end
        else
        begin
            word_len_reg <= word_len_next;
            bit_pos_reg  <= bit_pos_next;
            reps_reg     <= reps_next;
            tick_reg     <= tick_next;
            ucnt_reg     <= ucnt_next;
            phase_reg    <= phase_next;
            line_reg     <= line_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: one result item per accepted item
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept_in)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            out_item_reg.line_level    <= line_next;
            out_item_reg.sending       <= (phase_next != ook_tx_pkg::PH_IDLE);
            out_item_reg.frame_done    <= done;
            out_item_reg.load_rejected <= rejected;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a completed sequence is never reported as still sending
    a_done_not_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.frame_done && out_item_reg.sending))
        else $error("frame_done with sending set");

    // the line only goes high while bits are being sent
    a_line_low_off_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ook_tx_pkg::PH_IDLE || phase_reg == ook_tx_pkg::PH_GAP)
        |-> !line_reg)
        else $error("line high outside bit phase");

    // bit pointer stays inside the loaded word while sending bits
    a_bit_pos_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ook_tx_pkg::PH_BITS) |-> (bit_pos_reg < word_len_reg))
        else $error("bit position past word length");

    // a refused load leaves the word length unchanged
    a_reject_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && rejected && !done) |=> $stable(word_len_reg))
        else $error("rejected load changed word length");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for pulse_code_ook_transmitter_unit: directed and random item traffic, an
// in-bench line predictor and a result scoreboard. Depends on ook_tx_pkg and the unit's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_MAX      = ook_tx_pkg::MAX_BITS_DEF;
    localparam int RANDOM_ITEMS  = 600;
    localparam int QUIET_LIMIT   = 3000;    // cycles with no item or write moving
    localparam int DRAIN_LIMIT   = 3000;
    localparam int REPORT_MAX    = 10;
    localparam logic [ook_tx_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT ports. Everything is driven at the falling edge
    // and sampled at the rising edge.
    // ---------------------------------------------------------------------
    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [ook_tx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ook_tx_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    ook_tx_pkg::in_item_t              in_item   = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    ook_tx_pkg::out_item_t             out_item;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pulse_code_ook_transmitter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // ---------------------------------------------------------------------
    // Line predictor: register copies plus transmitter state at the
    // block's widths. Updated by the sender when an item is accepted and
    // by the register write task, so it always runs in item order.
    // ---------------------------------------------------------------------
    logic [ook_tx_pkg::TICK_W-1:0]   unit_ticks = ook_tx_pkg::PULSE_UNIT_RST;
    logic [ook_tx_pkg::REPEAT_W-1:0] pass_total = ook_tx_pkg::REPEAT_RST;
    logic                            tx_on      = 1'b0;

    logic                              word_bits [WORD_MAX] = '{default: 1'b0};
    logic [6:0]                        word_len    = '0;
    logic [6:0]                        bit_pos     = '0;
    logic [ook_tx_pkg::REPEAT_W-1:0]   passes_sent = '0;
    ook_tx_pkg::phase_t                tx_phase    = ook_tx_pkg::PH_IDLE;
    logic [ook_tx_pkg::TICK_W-1:0]     tick_cnt    = '0;
    logic [ook_tx_pkg::UNIT_CNT_W-1:0] gap_units   = '0;
    logic                              tx_busy     = 1'b0;
    logic                              tx_line     = 1'b0;

    ook_tx_pkg::out_item_t line_results_due[$];     // predicted results, oldest first
    int        bad_results = 0;
    int        items_sent  = 0;
    bit        tx_gaps_on  = 1'b1;      // sender may idle between items
    int        rx_hold_req = 0;         // asks the receiver for one long hold-off

    function automatic void end_frames();
        tx_busy     = 1'b0;
        tx_phase    = ook_tx_pkg::PH_IDLE;
        tx_line     = 1'b0;
        word_len    = '0;
        bit_pos     = '0;
        passes_sent = '0;
        tick_cnt    = '0;
        gap_units   = '0;
    endfunction

    function automatic void begin_pass();
        tx_phase  = ook_tx_pkg::PH_BITS;
        bit_pos   = '0;
        tick_cnt  = '0;
        gap_units = '0;
        tx_line   = (word_len != 0) ? word_bits[0] : 1'b0;
    endfunction

    // 1 when the whole sequence is already over
    function automatic logic start_frames();
        if (pass_total == 0 || !tx_on || word_len == 0)
        begin
            end_frames();
            return 1'b1;
        end
        tx_busy     = 1'b1;
        passes_sent = '0;
        begin_pass();
        return 1'b0;
    endfunction

    // One microsecond of line time while a sequence runs; 1 when it ends
    function automatic logic advance_tick();
        logic [ook_tx_pkg::TICK_W:0] unit_len;
        unit_len = (unit_ticks == 0) ? (ook_tx_pkg::TICK_W+1)'(1) : {1'b0, unit_ticks};
        if (!tx_on)
        begin
            end_frames();
            return 1'b1;
        end
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt != 0 && {1'b0, tick_cnt} < unit_len)
            return 1'b0;
        tick_cnt = '0;

        if (tx_phase == ook_tx_pkg::PH_BITS)
        begin
            bit_pos = bit_pos + 1'b1;
            if (bit_pos >= word_len || bit_pos >= WORD_MAX)
            begin
                tx_phase  = ook_tx_pkg::PH_GAP;
                gap_units = '0;
                tx_line   = 1'b0;
            end
            else
                tx_line = word_bits[bit_pos[5:0]];
            return 1'b0;
        end

        // sync gap, line held low
        gap_units = gap_units + 1'b1;
        tx_line   = 1'b0;
        if (gap_units < ook_tx_pkg::SYNC_UNITS)
            return 1'b0;
        passes_sent = passes_sent + 1'b1;
        if (passes_sent >= pass_total || passes_sent == 0)
        begin
            end_frames();
            return 1'b1;
        end
        begin_pass();
        return 1'b0;
    endfunction

    function automatic ook_tx_pkg::out_item_t line_result_for(ook_tx_pkg::in_item_t it);
        ook_tx_pkg::out_item_t r;
        logic done;
        logic refused;
        done    = 1'b0;
        refused = 1'b0;
        if (it.req_type == ook_tx_pkg::REQ_LOAD)
        begin
            if (tx_busy)
                refused = 1'b1;
            else
            begin
                if (word_len >= WORD_MAX)
                    refused = 1'b1;
                else
                begin
                    word_bits[word_len[5:0]] = it.code_bit;
                    word_len = word_len + 1'b1;
                end
                if (it.last_bit)
                    done = start_frames();
            end
        end
        else if (tx_busy)
            done = advance_tick();
        else
            tx_line = 1'b0;

        r.line_level    = tx_line;
        r.sending       = tx_busy;
        r.frame_done    = done;
        r.load_rejected = refused;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    task automatic send_item(input logic rq, input logic cb, input logic lb);
        ook_tx_pkg::in_item_t it;
        int       gap;
        int       pick;
        it.req_type = rq;
        it.code_bit = cb;
        it.last_bit = lb;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        line_results_due.push_back(line_result_for(it));
        items_sent++;

        // idle gap: mostly none or short, a few long
        gap = 0;
        if (tx_gaps_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 98)
                gap = $urandom_range(20, 40);
            else if (pick >= 90)
                gap = $urandom_range(4, 12);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_load(input logic b, input logic last);
        send_item(ook_tx_pkg::REQ_LOAD, b, last);
    endtask

    // code and last bits are don't-care on a tick; keep them moving anyway
    task automatic send_tick();
        send_item(ook_tx_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_until_idle(input int cap);
        int n;
        n = 0;
        while (tx_busy && n < cap)
        begin
            send_tick();
            n++;
        end
    endtask

    // Register write: only with nothing in flight. Every item returns one
    // result, so an empty scoreboard means the unit holds no item.
    task automatic write_reg(input logic [ook_tx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ook_tx_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ook_tx_pkg::CFG_PULSE_UNIT: unit_ticks = val;
            ook_tx_pkg::CFG_REPEAT:     pass_total = val[ook_tx_pkg::REPEAT_W-1:0];
            ook_tx_pkg::CFG_TX_ENABLE:  tx_on      = val[0];
            default: ;      // no register there
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Receiver pacing: alternating free and stalled stretches, mostly
    // short, now and then long; a test can ask for one long hold-off.
    // ---------------------------------------------------------------------
    initial
    begin : rx_pacing
        int   left;
        int   pick;
        logic level;
        left  = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req != 0)
            begin
                level       = 1'b1;
                left        = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (left == 0)
            begin
                level = !level;
                pick  = $urandom_range(0, 99);
                if (level)
                    left = (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
                else
                    left = (pick < 92) ? $urandom_range(1, 8) : $urandom_range(100, 300);
            end
            out_stall <= level;
            left--;
        end
    end

    // ---------------------------------------------------------------------
    // Result check: each accepted result against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        ook_tx_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_results_due.size() == 0)
            begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("%0t: result with no item outstanding: %b", $time, out_item);
            end
            else
            begin
                want = line_results_due.pop_front();
                if (out_item.line_level    !== want.line_level ||
                    out_item.sending       !== want.sending    ||
                    out_item.frame_done    !== want.frame_done ||
                    out_item.load_rejected !== want.load_rejected)
                begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display({"%0t: result mismatch  want line=%b sending=%b done=%b ",
                                  "rejected=%b  got line=%b sending=%b done=%b rejected=%b"},
                                 $time, want.line_level, want.sending, want.frame_done,
                                 want.load_rejected, out_item.line_level, out_item.sending,
                                 out_item.frame_done, out_item.load_rejected);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Idle ticks, start with transmit off (reset value), start with zero
    // repeats, write to the unused register slot.
    task automatic test_idle_and_instant_finish();
        send_tick();
        send_tick();
        send_load(1'b1, 1'b0);
        send_load(1'b0, 1'b1);
        write_reg(CFG_UNUSED_IDX, '1);
        write_reg(ook_tx_pkg::CFG_TX_ENABLE, ook_tx_pkg::CFG_DATA_W'(1));
        write_reg(ook_tx_pkg::CFG_REPEAT, '0);
        send_load(1'b1, 1'b1);
        send_tick();
    endtask

    // Complete two-pass frame, pulse unit zero acting as one tick
    task automatic test_full_frame();
        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, '0);
        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(2));
        send_load(1'b1, 1'b0);
        send_load(1'b0, 1'b0);
        send_load(1'b1, 1'b1);
        run_until_idle(300);
        send_tick();
    endtask

    // Fill the store, start from a refused load, refuse a load mid-frame,
    // then switch transmit off during the sync gap.
    task automatic test_full_store_and_busy_load();
        int k;
        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, ook_tx_pkg::CFG_DATA_W'(1));
        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(1));
        for (k = 0; k < WORD_MAX; k++)
            send_load(1'($urandom_range(0, 1)), 1'b0);
        send_load(1'b1, 1'b1);
        repeat (10) send_tick();
        send_load(1'b1, 1'b1);
        while (tx_phase == ook_tx_pkg::PH_BITS)
            send_tick();
        repeat (5) send_tick();
        write_reg(ook_tx_pkg::CFG_TX_ENABLE, '0);
        send_tick();
        send_tick();
        write_reg(ook_tx_pkg::CFG_TX_ENABLE, ook_tx_pkg::CFG_DATA_W'(1));
    endtask

    // Largest pulse unit and repeat count, then both lowered mid-sequence
    task automatic test_register_extremes();
        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, '1);
        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(255));
        send_load(1'b0, 1'b0);
        send_load(1'b1, 1'b1);
        repeat (20) send_tick();
        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, ook_tx_pkg::CFG_DATA_W'(2));
        repeat (10) send_tick();
        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(1));
        run_until_idle(300);
    endtask

    // Receiver holds off while the sender keeps offering ticks back to back
    task automatic test_output_backpressure();
        int k;
        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, ook_tx_pkg::CFG_DATA_W'(1));
        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(1));
        tx_gaps_on = 1'b0;
        for (k = 0; k < 5; k++)
            send_load(1'($urandom_range(0, 1)), k == 4);
        rx_hold_req = 200;
        repeat (40) send_tick();
        run_until_idle(200);
        tx_gaps_on = 1'b1;
    endtask

    // Mostly well-formed words followed by ticks, with random settings,
    // refused loads mid-frame, register changes mid-frame and plain noise.
    task automatic test_random_traffic();
        int                                first;
        int                                n;
        int                                k;
        int                                cap;
        int                                pick;
        logic [ook_tx_pkg::CFG_DATA_W-1:0] val;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);

            if (!tx_on || $urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    val = '0;
                else if (pick <= 6)
                    val = ook_tx_pkg::CFG_DATA_W'($urandom_range(1, 3));
                else if (pick <= 8)
                    val = ook_tx_pkg::CFG_DATA_W'($urandom_range(4, 8));
                else
                    val = '1;
                write_reg(ook_tx_pkg::CFG_PULSE_UNIT, val);
                // upper data bits are outside the register and must not matter
                pick = $urandom_range(0, 19);
                val  = {8'($urandom), 8'($urandom_range(1, 3))};
                if (pick < 2)
                    val[7:0] = '0;
                else if (pick == 2)
                    val[7:0] = 8'd255;
                write_reg(ook_tx_pkg::CFG_REPEAT, val);
                val    = ook_tx_pkg::CFG_DATA_W'($urandom);
                val[0] = ($urandom_range(0, 9) != 0);
                write_reg(ook_tx_pkg::CFG_TX_ENABLE, val);
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_UNUSED_IDX, ook_tx_pkg::CFG_DATA_W'($urandom));
            end

            if ($urandom_range(0, 7) == 0)
            begin
                // noise: any field combination
                repeat ($urandom_range(1, 20))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                for (k = 1; k <= n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_tick();
                    send_load(1'($urandom_range(0, 1)), k == n);
                end

                cap = $urandom_range(50, 400);
                k   = 0;
                while (tx_busy && k < cap)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_load(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        send_tick();
                    k++;
                end

                // still running: cut it short through the registers
                if (tx_busy)
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_reg(ook_tx_pkg::CFG_TX_ENABLE, '0);
                    else
                    begin
                        write_reg(ook_tx_pkg::CFG_PULSE_UNIT, ook_tx_pkg::CFG_DATA_W'(1));
                        write_reg(ook_tx_pkg::CFG_REPEAT, ook_tx_pkg::CFG_DATA_W'(1));
                    end
                    run_until_idle(400);
                end
            end
        end
        tx_gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin : main
        int waited;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_instant_finish();
        test_full_frame();
        test_full_store_and_busy_load();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (line_results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (line_results_due.size() != 0)
        begin
            $display("%0d predicted results never arrived", line_results_due.size());
            bad_results += line_results_due.size();
        end

        if (bad_results == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
